// ----- hdl/ssp_pkg.sv -----
package ssp_pkg;

  // default parameter values
  localparam int MOTORS_DEF      = 4;
  localparam int COUNT_WIDTH_DEF = 32;

  // field widths
  localparam int CLK_W   = 32;
  localparam int SPEED_W = 31;
  localparam int USTEP_W = 9;
  localparam int MCNT_W  = 3;
  localparam int MASK_W  = 4;
  localparam int STEPS_W = 24;
  localparam int REM_W   = 31;
  localparam int RATE_W  = SPEED_W + USTEP_W;
  localparam int TOTAL_W = STEPS_W + USTEP_W;
  localparam int CFG_IDX_W = 3;

  // narrow timer period limit
  localparam logic [CLK_W-1:0] NARROW_MAX = 32'd65535;

  // action codes
  typedef logic [1:0] action_t;
  localparam action_t ACT_TICK = 2'd0;
  localparam action_t ACT_MOVE = 2'd1;
  localparam action_t ACT_STOP = 2'd2;

  // status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_BAD_MOTOR = 2'd1;
  localparam status_t ST_BAD_SPEED = 2'd2;
  localparam status_t ST_BUSY      = 2'd3;

  // configuration register indexes
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_TIMER_CLK  = 3'd0;
  localparam cfg_idx_t CFG_SPEED      = 3'd1;
  localparam cfg_idx_t CFG_MICROSTEPS = 3'd2;
  localparam cfg_idx_t CFG_NARROW     = 3'd3;
  localparam cfg_idx_t CFG_MOTOR_CNT  = 3'd4;
  localparam cfg_idx_t CFG_ENABLE     = 3'd5;

  // controller to datapath commands
  typedef struct packed {
    logic    do_tick;
    logic    do_stop;
    logic    latch_move;
    logic    do_mul;
    logic    div_start;
    logic    commit;
    logic    emit;
    status_t res_status;
  } ssp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic    early_done;
    status_t early_status;
    logic    rate_bad;
    logic    div_done;
  } ssp_stat_t;

endpackage

// ----- hdl/ssp_div.sv -----
module ssp_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [ssp_pkg::CLK_W-1:0] dividend,
  input  logic [ssp_pkg::CLK_W-1:0] divisor,
  output logic                     done,
  output logic [ssp_pkg::CLK_W-1:0] quotient
);
  import ssp_pkg::*;

  localparam int CNT_W = $clog2(CLK_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CLK_W-1:0] rem_r, rem_nxt;
  logic [CLK_W-1:0] quo_r, quo_nxt;
  logic [CLK_W:0]   trial;
  logic [CLK_W:0]   diff;

  // one quotient bit per cycle, restoring
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    trial    = {rem_r, quo_r[CLK_W-1]};
    diff     = trial - {1'b0, divisor};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      if (!diff[CLK_W]) begin
        rem_nxt = diff[CLK_W-1:0];
        quo_nxt = {quo_r[CLK_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[CLK_W-1:0];
        quo_nxt = {quo_r[CLK_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(CLK_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- hdl/ssp_dp.sv -----
module ssp_dp #(
  parameter int MOTORS      = ssp_pkg::MOTORS_DEF,
  parameter int COUNT_WIDTH = ssp_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ssp_pkg::ssp_cmd_t             cmd,
  output ssp_pkg::ssp_stat_t            stat,
  input  logic [1:0]                    in_motor,
  input  logic signed [ssp_pkg::STEPS_W-1:0] in_steps,
  input  logic                          cfg_we,
  input  ssp_pkg::cfg_idx_t             cfg_index,
  input  logic [ssp_pkg::CLK_W-1:0]     cfg_data,
  output logic                          out_step_pin,
  output logic                          out_direction,
  output logic [1:0]                    out_active_motor,
  output logic [ssp_pkg::MASK_W-1:0]    out_enable_pins,
  output logic                          out_busy_res,
  output logic                          out_done_res,
  output ssp_pkg::status_t              out_status,
  output logic [ssp_pkg::REM_W-1:0]     out_remaining
);
  import ssp_pkg::*;

  localparam logic [REM_W-1:0] REM_MAX = '1;

  // configuration registers
  logic [CLK_W-1:0]   tclk_r;
  logic [SPEED_W-1:0] speed_r;
  logic [USTEP_W-1:0] usteps_r;
  logic               narrow_r;
  logic [MCNT_W-1:0]  mcount_r;
  logic [MASK_W-1:0]  enable_r;

  // move state
  logic [REM_W-1:0]       pending_r, pending_nxt;
  logic [COUNT_WIDTH-1:0] pre_val_r, pre_val_nxt;
  logic [COUNT_WIDTH-1:0] reload_r, reload_nxt;
  logic [COUNT_WIDTH-1:0] pre_cnt_r, pre_cnt_nxt;
  logic [COUNT_WIDTH-1:0] period_r, period_nxt;
  logic                   moving_r, moving_nxt;
  logic                   dir_r, dir_nxt;
  logic [1:0]             motor_r, motor_nxt;

  // move setup registers
  logic [1:0]         mv_motor_r;
  logic               mv_neg_r;
  logic [STEPS_W-1:0] mv_mag_r;
  logic [RATE_W-1:0]  rate_r;
  logic [REM_W-1:0]   total_r;

  logic [MCNT_W-1:0]  present;
  logic               bad_motor;
  logic               steps_neg;
  logic [STEPS_W-1:0] steps_mag;
  logic [TOTAL_W-1:0] total_w;
  logic [RATE_W-1:0]  rate_w;
  logic               div_done;
  logic [CLK_W-1:0]   quot;
  logic [CLK_W-1:0]   reload_w;
  logic [CLK_W-1:0]   pre_w;
  logic [COUNT_WIDTH:0] half;
  logic               pin;
  logic               done;

  function automatic logic [COUNT_WIDTH-1:0] sat_cnt(input logic [CLK_W-1:0] v);
    logic [CLK_W-1:0] hi;
    hi = v >> COUNT_WIDTH;
    if (COUNT_WIDTH < CLK_W && hi != '0) return '1;
    return v[COUNT_WIDTH-1:0];
  endfunction

  // early checks on a move beat
  always_comb begin
    present   = (mcount_r < MCNT_W'(MOTORS)) ? mcount_r : MCNT_W'(MOTORS);
    bad_motor = {1'b0, in_motor} >= present;
    steps_neg = in_steps[STEPS_W-1];
    steps_mag = steps_neg ? (~in_steps + 1'b1) : in_steps;
    stat.early_done   = bad_motor || moving_r || (in_steps == '0);
    stat.early_status = bad_motor ? ST_BAD_MOTOR : (moving_r ? ST_BUSY : ST_OK);
    stat.rate_bad     = (rate_r == '0) || (rate_r > RATE_W'(tclk_r >> 1));
    stat.div_done     = div_done;
  end

  // scaled rate and step total
  always_comb begin
    rate_w  = RATE_W'(speed_r) * RATE_W'(usteps_r);
    total_w = TOTAL_W'(mv_mag_r) * TOTAL_W'(usteps_r);
  end

  ssp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (tclk_r),
    .divisor  (rate_r[CLK_W-1:0]),
    .done     (div_done),
    .quotient (quot)
  );

  // reload and prescale from the quotient
  always_comb begin
    reload_w = quot - 1'b1;
    pre_w    = '0;
    if (narrow_r && reload_w > NARROW_MAX) begin
      pre_w    = (quot >> 16) - 1'b1;
      reload_w = NARROW_MAX;
    end
  end

  // tick, stop and commit updates
  always_comb begin
    pending_nxt = pending_r;
    pre_val_nxt = pre_val_r;
    reload_nxt  = reload_r;
    pre_cnt_nxt = pre_cnt_r;
    period_nxt  = period_r;
    moving_nxt  = moving_r;
    dir_nxt     = dir_r;
    motor_nxt   = motor_r;
    pin         = 1'b0;
    done        = 1'b0;
    half        = ({1'b0, reload_r} + 1'b1) >> 1;
    if (cmd.do_tick && moving_r) begin
      pin = ({1'b0, period_r} < half) && enable_r[motor_r];
      if (pre_cnt_r >= pre_val_r) begin
        pre_cnt_nxt = '0;
        if (period_r >= reload_r) begin
          period_nxt = '0;
          if (pending_r != '0) pending_nxt = pending_r - 1'b1;
          if (pending_nxt == '0) begin
            moving_nxt = 1'b0;
            done       = 1'b1;
          end
        end else begin
          period_nxt = period_r + 1'b1;
        end
      end else begin
        pre_cnt_nxt = pre_cnt_r + 1'b1;
      end
    end else if (cmd.do_stop && moving_r) begin
      moving_nxt  = 1'b0;
      pending_nxt = '0;
      pre_cnt_nxt = '0;
      period_nxt  = '0;
      done        = 1'b1;
    end else if (cmd.commit) begin
      pending_nxt = total_r;
      reload_nxt  = sat_cnt(reload_w);
      pre_val_nxt = sat_cnt(pre_w);
      pre_cnt_nxt = '0;
      period_nxt  = '0;
      dir_nxt     = mv_neg_r;
      motor_nxt   = mv_motor_r;
      moving_nxt  = 1'b1;
    end
  end

  // configuration and move state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tclk_r    <= 32'd1000000;
      speed_r   <= SPEED_W'(1);
      usteps_r  <= USTEP_W'(1);
      narrow_r  <= 1'b1;
      mcount_r  <= MCNT_W'(1);
      enable_r  <= '0;
      pending_r <= '0;
      pre_val_r <= '0;
      reload_r  <= '0;
      pre_cnt_r <= '0;
      period_r  <= '0;
      moving_r  <= 1'b0;
      dir_r     <= 1'b0;
      motor_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TIMER_CLK:  tclk_r   <= cfg_data;
          CFG_SPEED:      speed_r  <= cfg_data[SPEED_W-1:0];
          CFG_MICROSTEPS: usteps_r <= cfg_data[USTEP_W-1:0];
          CFG_NARROW:     narrow_r <= cfg_data[0];
          CFG_MOTOR_CNT:  mcount_r <= cfg_data[MCNT_W-1:0];
          CFG_ENABLE:     enable_r <= cfg_data[MASK_W-1:0];
          default: ;
        endcase
      end
      pending_r <= pending_nxt;
      pre_val_r <= pre_val_nxt;
      reload_r  <= reload_nxt;
      pre_cnt_r <= pre_cnt_nxt;
      period_r  <= period_nxt;
      moving_r  <= moving_nxt;
      dir_r     <= dir_nxt;
      motor_r   <= motor_nxt;
    end
  end

  // move setup pipeline
  always_ff @(posedge clk) begin
    if (cmd.latch_move) begin
      mv_motor_r <= in_motor;
      mv_neg_r   <= steps_neg;
      mv_mag_r   <= steps_mag;
    end
    if (cmd.do_mul) begin
      rate_r  <= rate_w;
      total_r <= (total_w > TOTAL_W'(REM_MAX)) ? REM_MAX : total_w[REM_W-1:0];
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_step_pin     <= pin;
      out_direction    <= dir_nxt;
      out_active_motor <= motor_nxt;
      out_enable_pins  <= enable_r;
      out_busy_res     <= moving_nxt;
      out_done_res     <= done;
      out_status       <= cmd.res_status;
      out_remaining    <= pending_nxt;
    end
  end

endmodule

// ----- hdl/ssp_ctrl.sv -----
module ssp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ssp_pkg::action_t   in_action,
  output logic               out_valid,
  input  logic               out_stall,
  input  ssp_pkg::ssp_stat_t stat,
  output ssp_pkg::ssp_cmd_t  cmd
);
  import ssp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CHECK,
    S_DIV,
    S_COMMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   take;

  // sequencing of beats and move setup
  always_comb begin
    in_stall      = (state_r != S_IDLE) || (out_valid_r && out_stall);
    take          = in_valid && !in_stall;
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (take) begin
          case (in_action)
            ACT_TICK: begin
              cmd.do_tick = 1'b1;
              cmd.emit    = 1'b1;
            end
            ACT_MOVE: begin
              if (stat.early_done) begin
                cmd.emit       = 1'b1;
                cmd.res_status = stat.early_status;
              end else begin
                cmd.latch_move = 1'b1;
                state_nxt      = S_MUL;
              end
            end
            ACT_STOP: begin
              cmd.do_stop = 1'b1;
              cmd.emit    = 1'b1;
            end
            default: cmd.emit = 1'b1;
          endcase
        end
      end
      S_MUL: begin
        cmd.do_mul = 1'b1;
        state_nxt  = S_CHECK;
      end
      S_CHECK: begin
        if (stat.rate_bad) begin
          cmd.emit       = 1'b1;
          cmd.res_status = ST_BAD_SPEED;
          state_nxt      = S_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (stat.div_done) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        cmd.emit   = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cmd.emit) out_valid_nxt = 1'b1;
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- hdl/stepper_step_pulse_generator.sv -----
// Step and direction pulse generator for up to four stepper motors.
// Input channel (in_valid/in_stall) carries one beat per timer tick, move
// command or stop; every accepted beat yields exactly one result beat on the
// output channel (out_valid/out_stall) with pin levels, status and the
// remaining microstep count.
// Ticks, stops and moves refused by the motor, busy or zero-step check give
// their result in the cycle after acceptance; a new beat is taken every cycle
// while the result register drains, so ticks run at one per cycle.
// A move passes the latch, scale and range check states before the quotient
// unit; one refused by the range check gives its result from there.
// Otherwise the quotient unit forms one bit per cycle, followed by a hand-over
// step and the commit state, with the input stalled throughout.
// Configuration goes through cfg_valid/cfg_ready (always ready) with a
// register index and 32-bit data; the user must write it only while the block
// is idle, which the block itself does not enforce. Reset (rst_n low,
// synchronous) loads the register defaults, stops any move, empties the result
// register. While out_stall holds a result, the block takes no new input beat
// and the result payload stays unchanged.
module stepper_step_pulse_generator #(
  parameter int MOTORS      = ssp_pkg::MOTORS_DEF,
  parameter int COUNT_WIDTH = ssp_pkg::COUNT_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_action,
  input  logic [1:0]                         in_motor,
  input  logic signed [ssp_pkg::STEPS_W-1:0] in_steps,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_step_pin,
  output logic                               out_direction,
  output logic [1:0]                         out_active_motor,
  output logic [ssp_pkg::MASK_W-1:0]         out_enable_pins,
  output logic                               out_busy_res,
  output logic                               out_done_res,
  output logic [1:0]                         out_status,
  output logic [ssp_pkg::REM_W-1:0]          out_remaining,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ssp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ssp_pkg::CLK_W-1:0]          cfg_data
);
  import ssp_pkg::*;

  ssp_cmd_t  cmd;
  ssp_stat_t stat;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  ssp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_action (in_action),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ssp_dp #(
    .MOTORS      (MOTORS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_motor         (in_motor),
    .in_steps         (in_steps),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_step_pin     (out_step_pin),
    .out_direction    (out_direction),
    .out_active_motor (out_active_motor),
    .out_enable_pins  (out_enable_pins),
    .out_busy_res     (out_busy_res),
    .out_done_res     (out_done_res),
    .out_status       (out_status),
    .out_remaining    (out_remaining)
  );

endmodule

// ----- tb/stepper_step_pulse_generator_chk.sv -----
module stepper_step_pulse_generator_chk (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic [1:0]                         in_action,
  input  logic [1:0]                         in_motor,
  input  logic signed [ssp_pkg::STEPS_W-1:0] in_steps,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic                               out_step_pin,
  input  logic                               out_direction,
  input  logic [1:0]                         out_active_motor,
  input  logic [ssp_pkg::MASK_W-1:0]         out_enable_pins,
  input  logic                               out_busy_res,
  input  logic                               out_done_res,
  input  logic [1:0]                         out_status,
  input  logic [ssp_pkg::REM_W-1:0]          out_remaining,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [ssp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ssp_pkg::CLK_W-1:0]          cfg_data,
  output int                                 errors,
  output int                                 outstanding
);
  import ssp_pkg::*;

  localparam int MOTORS = MOTORS_DEF;
  localparam logic [63:0] USTEP_CAP = 64'h7FFF_FFFF;
  localparam logic [63:0] COUNT_CAP = 64'hFFFF_FFFF;

  // one result beat as the block should present it
  typedef struct packed {
    logic               step_pin;
    logic               direction;
    logic [1:0]         active_motor;
    logic [MASK_W-1:0]  enable_pins;
    logic               busy;
    logic               done;
    status_t            status;
    logic [REM_W-1:0]   remaining;
  } pulse_beat_t;

  // register copies
  logic [CLK_W-1:0]   tick_hz;
  logic [SPEED_W-1:0] full_rate;
  logic [USTEP_W-1:0] ustep_factor;
  logic               narrow;
  logic [MCNT_W-1:0]  motors_fitted;
  logic [MASK_W-1:0]  drive_mask;

  // motion state
  logic [REM_W-1:0] usteps_left;
  logic [31:0]      pre_limit, period_limit, pre_cnt, period_cnt;
  logic             running, dir_level;
  logic [1:0]       active_q;

  pulse_beat_t beats_due[$];
  int          miss_count = 0;
  int          due_count = 0;

  assign errors      = miss_count;
  assign outstanding = due_count;

  function automatic logic [31:0] clamp_count(logic [63:0] v);
    return (v > COUNT_CAP) ? COUNT_CAP[31:0] : v[31:0];
  endfunction

  // move command: checks, scaling and period setup
  function automatic status_t launch_move(logic [1:0] mtr, logic [STEPS_W-1:0] stp);
    logic [63:0] rate, quot, mag, total, reload, pre;
    int          present;
    present = (motors_fitted < MOTORS) ? int'(motors_fitted) : MOTORS;
    if (int'(mtr) >= present) return ST_BAD_MOTOR;
    if (running) return ST_BUSY;
    if (stp == '0) return ST_OK;
    rate = 64'(full_rate) * 64'(ustep_factor);
    if (rate == 0 || rate > 64'(tick_hz >> 1)) return ST_BAD_SPEED;
    mag = stp[STEPS_W-1] ? (64'h100_0000 - {40'b0, stp}) : {40'b0, stp};
    total = mag * 64'(ustep_factor);
    if (total > USTEP_CAP) total = USTEP_CAP;
    quot = 64'(tick_hz) / rate;
    reload = quot - 64'd1;
    pre = '0;
    if (narrow && reload > 64'd65535) begin
      pre = (quot >> 16) - 64'd1;
      reload = 64'd65535;
    end
    usteps_left  = total[REM_W-1:0];
    period_limit = clamp_count(reload);
    pre_limit    = clamp_count(pre);
    pre_cnt      = '0;
    period_cnt   = '0;
    dir_level    = stp[STEPS_W-1];
    active_q     = mtr;
    running      = 1'b1;
    return ST_OK;
  endfunction

  // advance the motion state by one accepted beat
  function automatic pulse_beat_t predict_beat(action_t act, logic [1:0] mtr,
                                               logic [STEPS_W-1:0] stp);
    pulse_beat_t res;
    logic [32:0] half;
    logic        pin, done;
    status_t     st;
    pin  = 1'b0;
    done = 1'b0;
    st   = ST_OK;
    case (act)
      ACT_TICK: begin
        if (running) begin
          half = ({1'b0, period_limit} + 33'd1) >> 1;
          if ({1'b0, period_cnt} < half && drive_mask[active_q]) pin = 1'b1;
          if (pre_cnt >= pre_limit) begin
            pre_cnt = '0;
            if (period_cnt >= period_limit) begin
              period_cnt = '0;
              if (usteps_left != 0) usteps_left = usteps_left - 1'b1;
              if (usteps_left == 0) begin
                running = 1'b0;
                done    = 1'b1;
              end
            end else begin
              period_cnt = period_cnt + 1'b1;
            end
          end else begin
            pre_cnt = pre_cnt + 1'b1;
          end
        end
      end
      ACT_MOVE: st = launch_move(mtr, stp);
      ACT_STOP: begin
        if (running) begin
          running     = 1'b0;
          usteps_left = '0;
          pre_cnt     = '0;
          period_cnt  = '0;
          done        = 1'b1;
        end
      end
      default: ;
    endcase
    res.step_pin     = pin;
    res.direction    = dir_level;
    res.active_motor = active_q;
    res.enable_pins  = drive_mask;
    res.busy         = running;
    res.done         = done;
    res.status       = st;
    res.remaining    = usteps_left;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    miss_count++;
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  // compare every field of one result beat
  task automatic compare_beat(pulse_beat_t want);
    if (out_step_pin != want.step_pin)
      report_mismatch("step_pin", out_step_pin, want.step_pin);
    if (out_direction != want.direction)
      report_mismatch("direction", out_direction, want.direction);
    if (out_active_motor != want.active_motor)
      report_mismatch("active_motor", out_active_motor, want.active_motor);
    if (out_enable_pins != want.enable_pins)
      report_mismatch("enable_pins", out_enable_pins, want.enable_pins);
    if (out_busy_res != want.busy)
      report_mismatch("busy_res", out_busy_res, want.busy);
    if (out_done_res != want.done)
      report_mismatch("done_res", out_done_res, want.done);
    if (out_status != want.status)
      report_mismatch("status", out_status, want.status);
    if (out_remaining != want.remaining)
      report_mismatch("remaining", out_remaining, want.remaining);
  endtask

  // watch configuration, results and input beats
  always @(posedge clk) begin
    if (!rst_n) begin
      tick_hz       = 32'd1_000_000;
      full_rate     = 31'd1;
      ustep_factor  = 9'd1;
      narrow        = 1'b1;
      motors_fitted = 3'd1;
      drive_mask    = '0;
      usteps_left   = '0;
      pre_limit     = '0;
      period_limit  = '0;
      pre_cnt       = '0;
      period_cnt    = '0;
      running       = 1'b0;
      dir_level     = 1'b0;
      active_q      = '0;
      beats_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TIMER_CLK:  tick_hz       = cfg_data;
          CFG_SPEED:      full_rate     = cfg_data[SPEED_W-1:0];
          CFG_MICROSTEPS: ustep_factor  = cfg_data[USTEP_W-1:0];
          CFG_NARROW:     narrow        = cfg_data[0];
          CFG_MOTOR_CNT:  motors_fitted = cfg_data[MCNT_W-1:0];
          CFG_ENABLE:     drive_mask    = cfg_data[MASK_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (beats_due.size() == 0)
          report_mismatch("result beat with nothing due", 1, 0);
        else
          compare_beat(beats_due.pop_front());
      end
      if (in_valid && !in_stall)
        beats_due.push_back(predict_beat(in_action, in_motor, in_steps));
    end
    due_count = beats_due.size();
  end

endmodule

// ----- tb/stepper_step_pulse_generator_tb.sv -----
module stepper_step_pulse_generator_tb;
  import ssp_pkg::*;

  localparam int      PERIOD       = 8;
  localparam int      LIMIT_CYCLES = 2000000;
  localparam int      LONG_HOLD    = 120;
  localparam int      ITEM_GOAL    = 1900;
  localparam int      PHASES       = 10;
  localparam action_t ACT_SPARE    = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_action = ACT_TICK;
  logic [1:0]           in_motor = '0;
  logic signed [STEPS_W-1:0] in_steps = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_step_pin;
  logic                 out_direction;
  logic [1:0]           out_active_motor;
  logic [MASK_W-1:0]    out_enable_pins;
  logic                 out_busy_res;
  logic                 out_done_res;
  logic [1:0]           out_status;
  logic [REM_W-1:0]     out_remaining;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CLK_W-1:0]     cfg_data = '0;

  int chk_errors;
  int due_count;

  // stimulus bookkeeping
  bit long_hold_req = 1'b0;
  bit steady = 1'b0;
  int motors_present = 1;
  int beats_sent = 0;
  int moves_sent = 0;
  int stops_sent = 0;
  int settings_used = 1;

  stepper_step_pulse_generator dut (.*);

  stepper_step_pulse_generator_chk chk (
    .*,
    .errors     (chk_errors),
    .outstanding(due_count)
  );

  // clock
  initial begin
    forever #(PERIOD / 2) clk = ~clk;
  end

  // run limit
  initial begin
    #(PERIOD * LIMIT_CYCLES);
    $display("stepper_step_pulse_generator_tb: FAIL");
    $finish;
  end

  // result side back-pressure, with one long hold on request
  initial begin : result_side
    int r;
    int n;
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        n = LONG_HOLD;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          out_stall <= 1'b0;
          n = $urandom_range(1, 12);
        end else if (r < 58) begin
          out_stall <= 1'b0;
          n = $urandom_range(40, 100);
        end else if (r < 90) begin
          out_stall <= 1'b1;
          n = $urandom_range(1, 3);
        end else if (r < 98) begin
          out_stall <= 1'b1;
          n = $urandom_range(4, 15);
        end else begin
          out_stall <= 1'b1;
          n = $urandom_range(30, 60);
        end
      end
      repeat (n) @(posedge clk);
    end
  end

  // idle the input with junk on the payload
  task automatic pause_in(int n);
    repeat (n) begin
      in_valid  <= 1'b0;
      in_action <= 2'($urandom);
      in_motor  <= 2'($urandom);
      in_steps  <= STEPS_W'($urandom);
      @(posedge clk);
    end
  endtask

  task automatic maybe_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 65) return;
    if (r < 92) pause_in($urandom_range(1, 3));
    else if (r < 98) pause_in($urandom_range(4, 10));
    else pause_in($urandom_range(20, 40));
  endtask

  // offer one beat and hold it until taken
  task automatic send_beat(action_t a, logic [1:0] m, logic [STEPS_W-1:0] s);
    in_valid  <= 1'b1;
    in_action <= a;
    in_motor  <= m;
    in_steps  <= s;
    do @(posedge clk); while (in_stall);
    beats_sent++;
    if (a == ACT_MOVE) moves_sent++;
    if (a == ACT_STOP) stops_sent++;
    maybe_gap();
  endtask

  task automatic tick_run(int n);
    repeat (n) send_beat(ACT_TICK, 2'($urandom), STEPS_W'($urandom));
  endtask

  // stop offering until every due result has come back
  task automatic drain();
    pause_in(1);
    while (due_count != 0) @(posedge clk);
    pause_in(4);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CLK_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == CFG_MOTOR_CNT) motors_present = (d[MCNT_W-1:0] < 4) ? int'(d[MCNT_W-1:0]) : 4;
  endtask

  // new register setting: short periods, or a mix of extremes
  task automatic set_profile(bit wild);
    logic [CLK_W-1:0] hz, spd, ustep, rate;
    int               pick;
    ustep = $urandom_range(1, 4);
    spd   = $urandom_range(1, 8);
    rate  = spd * ustep;
    hz    = rate * $urandom_range(2, 6) + $urandom_range(0, rate - 1);
    if (wild) begin
      pick = $urandom_range(0, 7);
      if (pick == 0) hz = '0;
      else if (pick == 1) hz = 32'd1;
      else if (pick == 2) hz = '1;
      else if (pick == 3) hz = $urandom;
      pick = $urandom_range(0, 7);
      if (pick == 0) spd = '0;
      else if (pick == 1) spd = 32'h7FFF_FFFF;
      else if (pick == 2) spd = $urandom;
      pick = $urandom_range(0, 7);
      if (pick == 0) ustep = '0;
      else if (pick == 1) ustep = 32'd256;
      else if (pick == 2) ustep = 32'd511;
    end
    write_reg(CFG_TIMER_CLK, hz);
    write_reg(CFG_SPEED, spd);
    write_reg(CFG_MICROSTEPS, ustep);
    write_reg(CFG_NARROW, $urandom_range(0, 1));
    write_reg(CFG_MOTOR_CNT, wild ? $urandom_range(0, 7) : $urandom_range(1, 4));
    write_reg(CFG_ENABLE, $urandom_range(0, 15));
    settings_used++;
  endtask

  // one random sequence: mostly a short move run out by ticks
  task automatic run_sequence();
    int               r;
    int               mag;
    logic [1:0]       m;
    logic [STEPS_W-1:0] s;
    r = $urandom_range(0, 99);
    steady = ($urandom_range(0, 4) == 0);
    m = (motors_present > 0) ? 2'($urandom_range(0, motors_present - 1)) : 2'($urandom);
    if ($urandom_range(0, 9) == 0) m = 2'($urandom);
    if (r < 65) begin
      mag = $urandom_range(1, 3);
      s = STEPS_W'($urandom_range(0, 1) ? -mag : mag);
      send_beat(ACT_MOVE, m, s);
      repeat ($urandom_range(4, 90)) begin
        r = $urandom_range(0, 59);
        if (r == 0) send_beat(ACT_MOVE, 2'($urandom), STEPS_W'($urandom));
        else if (r == 1) send_beat(ACT_STOP, 2'($urandom), STEPS_W'($urandom));
        else send_beat(ACT_TICK, 2'($urandom), STEPS_W'($urandom));
      end
      if ($urandom_range(0, 6) == 0) send_beat(ACT_STOP, 2'($urandom), STEPS_W'($urandom));
    end else if (r < 80) begin
      send_beat(ACT_MOVE, m, STEPS_W'($urandom));
      tick_run($urandom_range(1, 20));
      if ($urandom_range(0, 4) != 0) send_beat(ACT_STOP, 2'($urandom), STEPS_W'($urandom));
    end else begin
      repeat ($urandom_range(1, 6))
        send_beat(action_t'($urandom_range(0, 3)), 2'($urandom), STEPS_W'($urandom));
    end
    steady = 1'b0;
  endtask

  // main stimulus
  initial begin : stimulus
    int phase_end;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: slow prescaled timer, one motor, drivers off
    send_beat(ACT_TICK, 2'd0, '0);
    send_beat(ACT_MOVE, 2'd1, 24'd5);
    send_beat(ACT_MOVE, 2'd0, '0);
    send_beat(ACT_MOVE, 2'd0, 24'd1);
    send_beat(ACT_MOVE, 2'd0, 24'd2);
    tick_run(3);
    send_beat(ACT_STOP, 2'd3, '0);
    send_beat(ACT_STOP, 2'd0, '0);
    send_beat(ACT_SPARE, 2'd2, 24'hFFFFFF);
    drain();

    // two-tick period, all motors, alternate drivers enabled
    write_reg(CFG_TIMER_CLK, 32'd20);
    write_reg(CFG_SPEED, 32'd5);
    write_reg(CFG_MICROSTEPS, 32'd2);
    write_reg(CFG_NARROW, 32'd0);
    write_reg(CFG_MOTOR_CNT, 32'd4);
    write_reg(CFG_ENABLE, 32'hA);
    send_beat(ACT_MOVE, 2'd3, 24'hFFFFFE);
    tick_run(9);
    send_beat(ACT_MOVE, 2'd2, 24'h7FFFFF);
    tick_run(2);
    send_beat(ACT_STOP, 2'd0, '0);
    send_beat(ACT_MOVE, 2'd1, 24'h800000);
    send_beat(ACT_STOP, 2'd1, '0);
    drain();

    // rate at the half-clock edge, count saturation, then rejected rates
    write_reg(CFG_MICROSTEPS, 32'd256);
    write_reg(CFG_SPEED, 32'd1);
    write_reg(CFG_TIMER_CLK, 32'd512);
    send_beat(ACT_MOVE, 2'd0, 24'h800000);
    send_beat(ACT_STOP, 2'd0, '0);
    drain();
    write_reg(CFG_TIMER_CLK, 32'd511);
    send_beat(ACT_MOVE, 2'd0, 24'd1);
    drain();
    write_reg(CFG_TIMER_CLK, 32'd0);
    send_beat(ACT_MOVE, 2'd0, 24'd1);
    drain();
    write_reg(CFG_TIMER_CLK, 32'hFFFF_FFFF);
    write_reg(CFG_SPEED, 32'd0);
    send_beat(ACT_MOVE, 2'd0, 24'd1);
    drain();

    // widest clock, wide then narrow counter
    write_reg(CFG_SPEED, 32'd1);
    write_reg(CFG_MICROSTEPS, 32'd1);
    send_beat(ACT_MOVE, 2'd2, 24'd3);
    tick_run(3);
    send_beat(ACT_STOP, 2'd0, '0);
    drain();
    write_reg(CFG_NARROW, 32'd1);
    write_reg(CFG_ENABLE, 32'hF);
    send_beat(ACT_MOVE, 2'd3, 24'hFFFFFF);
    tick_run(3);
    send_beat(ACT_STOP, 2'd0, '0);
    drain();
    settings_used += 6;

    // random phases, every other one with extreme settings
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      set_profile(ph % 2 == 1);
      phase_end = beats_sent + (ITEM_GOAL - beats_sent) / (PHASES - ph);
      if (ph == 3) long_hold_req = 1'b1;
      while (beats_sent < phase_end) begin
        run_sequence();
        if (ph == 6 && $urandom_range(0, 3) == 0) drain();
      end
    end

    drain();
    pause_in(40);
    $display("covered %0d input beats with %0d moves and %0d stops over %0d settings",
             beats_sent, moves_sent, stops_sent, settings_used);
    if (chk_errors == 0) begin
      $display("stepper_step_pulse_generator_tb: PASS");
    end else begin
      $display("stepper_step_pulse_generator_tb: FAIL");
    end
    $finish;
  end

endmodule
